>>> sv/svsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package svsm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUNCH_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUNCH_LVLS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT   = 3'd6;

    localparam int CNT_W    = 24;
    localparam int MIX_W    = 24;
    localparam int DIVD_W   = 40;
    localparam int DIVR_W   = 24;
    localparam int DIV_CW   = 6;
    localparam int ENV_W    = 17;

    localparam logic [CNT_W-1:0] CNT_MAX     = 24'hFFFFFF;
    localparam logic [31:0]      SEED_RESET  = 32'h00C0FFEE;
    // Multiplier for an exact floor division by 125 of any value below 2^31,
    // followed by a right shift of 38.
    localparam logic [31:0]      RECIP_125   = 32'd2199023256;
    localparam int               RECIP_SHIFT = 38;
    localparam logic signed [31:0] ONE_Q16   = 32'sd65536;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIV_TOT,
        OP_SET_TOT,
        OP_DIV_GAP,
        OP_WRITE_VOICE,
        OP_DIV_ATT,
        OP_SET_ATT,
        OP_DIV_REL,
        OP_SET_REL,
        OP_VCHK,
        OP_SET_ENV,
        OP_VUPD,
        OP_VNEXT,
        OP_NPROD,
        OP_NADD,
        OP_VPROD,
        OP_VCLAMP,
        OP_CR_K,
        OP_SET_CR,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TOT,
        S_TOT_W,
        S_GAP,
        S_GAP_W,
        S_ATT,
        S_ATT_W,
        S_REL,
        S_REL_W,
        S_VCHK,
        S_ENV_W,
        S_VUPD,
        S_VNEXT,
        S_NPROD,
        S_NADD,
        S_VPROD,
        S_VCLAMP,
        S_CRK,
        S_CR_W,
        S_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } svsm_cmd_t;

    typedef struct packed {
        logic enable;
        logic div_done;
        logic v_play;
        logic v_env_div;
        logic last_voice;
        logic noise_on;
        logic crunch_on;
        logic out_full;
    } svsm_status_t;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [DIVD_W-1:0] q);
        logic [CNT_W-1:0] r;
        r = (q > DIVD_W'(CNT_MAX)) ? CNT_MAX : q[CNT_W-1:0];
        return r;
    endfunction

    // Signed division by 65536 that truncates toward zero.
    function automatic logic signed [31:0] trunc_q16(input logic signed [47:0] p);
        logic signed [47:0] b;
        b = p + (p[47] ? 48'sd65535 : 48'sd0);
        return $signed(b[47:16]);
    endfunction

endpackage
`default_nettype wire

>>> sv/svsm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface svsm_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] phase_step;
    logic [15:0] tone_ms;
    logic [15:0] gap_ms;
    modport source (output valid, cmd, phase_step, tone_ms, gap_ms, input ready);
    modport sink (input valid, cmd, phase_step, tone_ms, gap_ms, output ready);
endinterface
`default_nettype wire

>>> sv/svsm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface svsm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_value;
    logic [7:0]         active_voices;
    modport source (output valid, sample_value, active_voices, input ready);
    modport sink (input valid, sample_value, active_voices, output ready);
endinterface
`default_nettype wire

>>> sv/svsm_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface svsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [17:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/svsm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module svsm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [svsm_pkg::DIVD_W-1:0] dividend,
    input  wire logic [svsm_pkg::DIVR_W-1:0] divisor,
    output logic                            done,
    output logic [svsm_pkg::DIVD_W-1:0]      quotient
);
    import svsm_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dsr_reg;

    logic [DIVR_W:0]   trial;
    logic              ge;
    logic [DIVR_W-1:0] rem_step;

    // Restoring division, one quotient bit a cycle.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_step = ge ? DIVR_W'(trial - {1'b0, dsr_reg}) : trial[DIVR_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIVD_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            rem_reg <= rem_step;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

>>> sv/svsm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module svsm_dp #(
    parameter int VOICES     = 8,
    parameter int PHASE_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire svsm_pkg::svsm_cmd_t            cmd,
    output svsm_pkg::svsm_status_t              st,
    input  wire logic                           cfg_valid,
    input  wire logic [svsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [svsm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                cfg_ready,
    input  wire logic [31:0]                    in_phase_step,
    input  wire logic [15:0]                    in_tone_ms,
    input  wire logic [15:0]                    in_gap_ms,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic signed [15:0]                  sample_value,
    output logic [7:0]                          active_voices
);
    import svsm_pkg::*;

    localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MASK_N = (VOICES < 8) ? VOICES : 8;
    localparam int STEP_W = (PHASE_BITS > 32) ? PHASE_BITS : 32;

    // Configuration registers.
    logic        enable_reg;
    logic [17:0] rate_reg;
    logic [16:0] volume_reg;
    logic [13:0] noise_reg;
    logic        crunch_en_reg;
    logic [15:0] levels_reg;
    logic        eight_reg;

    // Voice state.
    logic [VOICES-1:0]     act_reg;
    logic [PHASE_BITS-1:0] phase_reg [VOICES];
    logic [PHASE_BITS-1:0] step_reg  [VOICES];
    logic [CNT_W-1:0]      left_reg  [VOICES];
    logic [CNT_W-1:0]      vtot_reg  [VOICES];
    logic [CNT_W-1:0]      vgap_reg  [VOICES];

    logic [IDX_W-1:0]        idx_reg;
    logic [31:0]             seed_reg;
    logic [31:0]             pstep_reg;
    logic [15:0]             tone_reg;
    logic [15:0]             gapms_reg;
    logic [CNT_W-1:0]        total_reg;
    logic [CNT_W-1:0]        att_reg;
    logic [CNT_W-1:0]        rel_reg;
    logic [ENV_W-1:0]        env_reg;
    logic signed [MIX_W-1:0] mix_reg;
    logic signed [47:0]      prod_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      sample_reg;
    logic [7:0]              mask_reg;
    logic [30:0]             conv_reg;
    logic                    conv_done_reg;

    logic                    div_start;
    logic [DIVD_W-1:0]       div_dividend;
    logic [DIVR_W-1:0]       div_divisor;
    logic                    div_done;
    logic [DIVD_W-1:0]       div_quo;

    svsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic                  cur_act;
    logic [CNT_W-1:0]      cur_left, cur_tot, cur_gap, pos;
    logic [PHASE_BITS-1:0] new_phase;
    logic                  att_hit, rel_hit, v_play, v_env_div;
    logic [IDX_W-1:0]      pick;
    logic                  found;
    logic [STEP_W-1:0]     step_wide;
    logic [15:0]           ms_sel;
    logic [33:0]           rate_prod;
    logic [62:0]           conv_prod;
    logic [DIVD_W-1:0]     conv_quo;
    logic [CNT_W-1:0]      tot_sat;
    logic [15:0]           lm1;
    logic [17:0]           cr_u;
    logic [33:0]           cr_uprod;
    logic [17:0]           cr_k;
    logic [DIVD_W-1:0]     cr_dividend;
    logic [31:0]           x1, x2, x3;
    logic signed [17:0]    noise_n;
    logic signed [47:0]    mix48;
    logic signed [47:0]    noise_prod, vol_prod, out_prod;
    logic signed [31:0]    t_vol, t_cr, t_out;
    logic signed [31:0]    c_vol, c_cr;
    logic signed [15:0]    sample_calc;
    logic [7:0]            mask_calc;

    assign cur_act  = act_reg[idx_reg];
    assign cur_left = left_reg[idx_reg];
    assign cur_tot  = vtot_reg[idx_reg];
    assign cur_gap  = vgap_reg[idx_reg];
    assign pos      = cur_tot - cur_left;
    assign new_phase = phase_reg[idx_reg] + step_reg[idx_reg];

    assign att_hit   = (att_reg != '0) && (pos < att_reg);
    assign rel_hit   = (rel_reg != '0) && (cur_left < rel_reg);
    assign v_play    = cur_act && (cur_gap == '0) && (cur_left != '0);
    assign v_env_div = v_play && (att_hit || rel_hit);

    always_comb
    begin
        pick  = '0;
        found = 1'b0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (!found && !act_reg[v])
            begin
                pick  = IDX_W'(v);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        mask_calc = '0;
        for (int v = 0; v < MASK_N; v++)
            mask_calc[v] = act_reg[v];
    end

    assign step_wide = STEP_W'(pstep_reg);

    always_comb
    begin
        case (cmd.op)
            OP_DIV_GAP: ms_sel = gapms_reg;
            OP_DIV_ATT: ms_sel = 16'd5;
            OP_DIV_REL: ms_sel = 16'd10;
            default:    ms_sel = tone_reg;
        endcase
    end

    // Division by 1000: the product is registered after a shift by 3, then
    // divided by 125 through a reciprocal multiplication in the next cycle.
    assign rate_prod = 34'(rate_reg) * 34'(ms_sel);
    assign conv_prod = 63'(conv_reg) * 63'(RECIP_125);
    assign conv_quo  = DIVD_W'(conv_prod[62:RECIP_SHIFT]);
    assign tot_sat   = sat_cnt(conv_quo);

    // Crunch: k is found by a shift, the level value by the shared divider.
    assign lm1         = levels_reg - 16'd1;
    assign cr_u        = 18'(mix_reg + MIX_W'(ONE_Q16));
    assign cr_uprod    = 34'(cr_u) * 34'(lm1);
    assign cr_k        = 18'((35'(cr_uprod) + 35'd65536) >> 17);
    assign cr_dividend = {5'b0, cr_k, 17'b0} + DIVD_W'(lm1 >> 1);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = cr_dividend;
        div_divisor  = DIVR_W'(lm1);
        case (cmd.op)
            OP_VCHK:
            begin
                div_start = v_env_div;
                if (att_hit)
                begin
                    div_dividend = {pos, 16'b0};
                    div_divisor  = att_reg;
                end
                else
                begin
                    div_dividend = {cur_left, 16'b0};
                    div_divisor  = rel_reg;
                end
            end
            OP_CR_K:
                div_start = 1'b1;
            default:
                div_start = 1'b0;
        endcase
    end

    assign x1 = seed_reg ^ (seed_reg << 13);
    assign x2 = x1 ^ (x1 >> 17);
    assign x3 = x2 ^ (x2 << 5);
    assign noise_n = $signed({1'b0, x3[15:0], 1'b0}) - 18'sd65536;

    assign mix48      = 48'(mix_reg);
    assign noise_prod = 48'(noise_n) * 48'($signed({1'b0, noise_reg}));
    assign vol_prod   = mix48 * 48'($signed({1'b0, volume_reg}));
    assign out_prod   = mix48 * (eight_reg ? 48'sd127 : 48'sd32767);

    assign t_vol = trunc_q16(prod_reg);
    assign t_cr  = $signed({8'b0, div_quo[23:0]}) - ONE_Q16;
    assign t_out = trunc_q16(out_prod);

    always_comb
    begin
        c_vol = t_vol;
        if (t_vol < -ONE_Q16)
            c_vol = -ONE_Q16;
        else if (t_vol > ONE_Q16)
            c_vol = ONE_Q16;
        c_cr = t_cr;
        if (t_cr < -ONE_Q16)
            c_cr = -ONE_Q16;
        else if (t_cr > ONE_Q16)
            c_cr = ONE_Q16;
    end

    always_comb
    begin
        if (!enable_reg)
            sample_calc = '0;
        else if (eight_reg)
            sample_calc = 16'(t_out + 32'sd128);
        else if (t_out < -32'sd32768)
            sample_calc = -16'sd32768;
        else if (t_out > 32'sd32767)
            sample_calc = 16'sd32767;
        else
            sample_calc = 16'(t_out);
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            rate_reg      <= 18'd22050;
            volume_reg    <= '0;
            noise_reg     <= '0;
            crunch_en_reg <= 1'b0;
            levels_reg    <= 16'd16;
            eight_reg     <= 1'b0;
            act_reg       <= '0;
            idx_reg       <= '0;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
            conv_done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ENABLE:      enable_reg    <= cfg_data[0];
                    CFG_SAMPLE_RATE: rate_reg      <= cfg_data[17:0];
                    CFG_VOLUME:      volume_reg    <= cfg_data[16:0];
                    CFG_NOISE_LEVEL: noise_reg     <= cfg_data[13:0];
                    CFG_CRUNCH_EN:   crunch_en_reg <= cfg_data[0];
                    CFG_CRUNCH_LVLS: levels_reg    <= cfg_data[15:0];
                    CFG_EIGHT_BIT:   eight_reg     <= cfg_data[0];
                    default:         ;
                endcase
            end

            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            conv_done_reg <= (cmd.op == OP_DIV_TOT) || (cmd.op == OP_DIV_GAP) ||
                             (cmd.op == OP_DIV_ATT) || (cmd.op == OP_DIV_REL);

            case (cmd.op)
                OP_LATCH:
                    idx_reg <= '0;
                OP_WRITE_VOICE:
                    act_reg[pick] <= 1'b1;
                OP_VCHK:
                    if (cur_act && cur_gap == '0 && cur_left == '0)
                        act_reg[idx_reg] <= 1'b0;
                OP_VUPD:
                    if (cur_left == CNT_W'(1))
                        act_reg[idx_reg] <= 1'b0;
                OP_VNEXT:
                    idx_reg <= st.last_voice ? '0 : idx_reg + 1'b1;
                OP_NPROD:
                    seed_reg <= x3;
                default:
                    ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                pstep_reg <= in_phase_step;
                tone_reg  <= in_tone_ms;
                gapms_reg <= in_gap_ms;
                mix_reg   <= '0;
            end
            OP_DIV_TOT, OP_DIV_GAP, OP_DIV_ATT, OP_DIV_REL:
                conv_reg <= rate_prod[33:3];
            OP_SET_TOT:
                total_reg <= (tot_sat == '0) ? CNT_W'(1) : tot_sat;
            OP_WRITE_VOICE:
            begin
                phase_reg[pick] <= '0;
                step_reg[pick]  <= step_wide[PHASE_BITS-1:0];
                left_reg[pick]  <= total_reg;
                vtot_reg[pick]  <= total_reg;
                vgap_reg[pick]  <= tot_sat;
            end
            OP_SET_ATT:
                att_reg <= conv_quo[CNT_W-1:0];
            OP_SET_REL:
                rel_reg <= conv_quo[CNT_W-1:0];
            OP_VCHK:
            begin
                if (cur_act && cur_gap != '0)
                    vgap_reg[idx_reg] <= cur_gap - 1'b1;
                env_reg <= ENV_W'(ONE_Q16);
            end
            OP_SET_ENV:
                env_reg <= div_quo[ENV_W-1:0];
            OP_VUPD:
            begin
                phase_reg[idx_reg] <= new_phase;
                left_reg[idx_reg]  <= cur_left - 1'b1;
                if (new_phase[PHASE_BITS-1])
                    mix_reg <= mix_reg - $signed(MIX_W'(env_reg));
                else
                    mix_reg <= mix_reg + $signed(MIX_W'(env_reg));
            end
            OP_NPROD:
                prod_reg <= noise_prod;
            OP_NADD:
                mix_reg <= mix_reg + MIX_W'(t_vol);
            OP_VPROD:
                prod_reg <= vol_prod;
            OP_VCLAMP:
                mix_reg <= MIX_W'(c_vol);
            OP_SET_CR:
                mix_reg <= MIX_W'(c_cr);
            OP_OUT:
            begin
                sample_reg <= sample_calc;
                mask_reg   <= mask_calc;
            end
            default:
                ;
        endcase
    end

    always_comb
    begin
        st.enable     = enable_reg;
        st.div_done   = div_done || conv_done_reg;
        st.v_play     = v_play;
        st.v_env_div  = v_env_div;
        st.last_voice = (idx_reg == IDX_W'(VOICES - 1));
        st.noise_on   = (noise_reg != '0);
        st.crunch_on  = crunch_en_reg && (levels_reg > 16'd1);
        st.out_full   = out_valid_reg && !out_ready;
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign sample_value  = sample_reg;
    assign active_voices = mask_reg;
endmodule
`default_nettype wire

>>> sv/svsm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module svsm_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_cmd,
    input  wire svsm_pkg::svsm_status_t st,
    output logic                        in_ready,
    output svsm_pkg::svsm_cmd_t         cmd
);
    import svsm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LATCH;
                    if (in_cmd)
                        state_next = st.enable ? S_TOT : S_IDLE;
                    else
                        state_next = st.enable ? S_ATT : S_OUT;
                end
            end
            S_TOT:
            begin
                cmd.op     = OP_DIV_TOT;
                state_next = S_TOT_W;
            end
            S_TOT_W:
                if (st.div_done)
                begin
                    cmd.op     = OP_SET_TOT;
                    state_next = S_GAP;
                end
            S_GAP:
            begin
                cmd.op     = OP_DIV_GAP;
                state_next = S_GAP_W;
            end
            S_GAP_W:
                if (st.div_done)
                begin
                    cmd.op     = OP_WRITE_VOICE;
                    state_next = S_IDLE;
                end
            S_ATT:
            begin
                cmd.op     = OP_DIV_ATT;
                state_next = S_ATT_W;
            end
            S_ATT_W:
                if (st.div_done)
                begin
                    cmd.op     = OP_SET_ATT;
                    state_next = S_REL;
                end
            S_REL:
            begin
                cmd.op     = OP_DIV_REL;
                state_next = S_REL_W;
            end
            S_REL_W:
                if (st.div_done)
                begin
                    cmd.op     = OP_SET_REL;
                    state_next = S_VCHK;
                end
            S_VCHK:
            begin
                cmd.op = OP_VCHK;
                if (st.v_env_div)
                    state_next = S_ENV_W;
                else if (st.v_play)
                    state_next = S_VUPD;
                else
                    state_next = S_VNEXT;
            end
            S_ENV_W:
                if (st.div_done)
                begin
                    cmd.op     = OP_SET_ENV;
                    state_next = S_VUPD;
                end
            S_VUPD:
            begin
                cmd.op     = OP_VUPD;
                state_next = S_VNEXT;
            end
            S_VNEXT:
            begin
                cmd.op     = OP_VNEXT;
                state_next = st.last_voice ? S_NPROD : S_VCHK;
            end
            S_NPROD:
            begin
                if (st.noise_on)
                begin
                    cmd.op     = OP_NPROD;
                    state_next = S_NADD;
                end
                else
                    state_next = S_VPROD;
            end
            S_NADD:
            begin
                cmd.op     = OP_NADD;
                state_next = S_VPROD;
            end
            S_VPROD:
            begin
                cmd.op     = OP_VPROD;
                state_next = S_VCLAMP;
            end
            S_VCLAMP:
            begin
                cmd.op     = OP_VCLAMP;
                state_next = st.crunch_on ? S_CRK : S_OUT;
            end
            S_CRK:
            begin
                cmd.op     = OP_CR_K;
                state_next = S_CR_W;
            end
            S_CR_W:
                if (st.div_done)
                begin
                    cmd.op     = OP_SET_CR;
                    state_next = S_OUT;
                end
            S_OUT:
                if (!st.out_full)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> sv/square_voice_synth_mixer_top.sv
// An enabled start converts the tone and gap times, writes a free voice and frees the
// input; a disabled start is dropped. A tick converts the attack and release times,
// visits every voice, waits on the shared divider for a voice in attack or release,
// adds the noise and crunch steps when on, and waits out any output stall. A disabled
// tick goes straight to the output state. Reset is asynchronous and active low; it
// resets the voices, noise seed and control registers at once, not the payload ones.
`timescale 1ns / 1ps
`default_nettype none
module square_voice_synth_mixer_top #(
    parameter int VOICES     = 8,
    parameter int PHASE_BITS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    svsm_in_if.sink     in_ch,
    svsm_out_if.source  out_ch,
    svsm_cfg_if.sink    cfg_ch
);
    import svsm_pkg::*;

    svsm_cmd_t    ctrl_cmd;
    svsm_status_t dp_status;

    svsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .st       (dp_status),
        .in_ready (in_ch.ready),
        .cmd      (ctrl_cmd)
    );

    svsm_dp #(
        .VOICES     (VOICES),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctrl_cmd),
        .st            (dp_status),
        .cfg_valid     (cfg_ch.valid),
        .cfg_index     (cfg_ch.index),
        .cfg_data      (cfg_ch.data),
        .cfg_ready     (cfg_ch.ready),
        .in_phase_step (in_ch.phase_step),
        .in_tone_ms    (in_ch.tone_ms),
        .in_gap_ms     (in_ch.gap_ms),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .sample_value  (out_ch.sample_value),
        .active_voices (out_ch.active_voices)
    );

    // A tick transaction always leaves the idle state.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !in_ch.cmd) |=> !in_ch.ready)
        else $error("tick accepted but controller stayed idle");

    // A new result appears only after the output step was commanded.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(ctrl_cmd.op == OP_OUT))
        else $error("result shown without output step");

    // A voice is only advanced when it is playing.
    a_vupd_play: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_cmd.op == OP_VUPD) |-> dp_status.v_play)
        else $error("voice advanced while not playing");

endmodule
`default_nettype wire
